>>> sv/two_way_exponential_quadrature_sweep_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-way exponential quadrature sweep
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TWO_WAY_EXPONENTIAL_QUADRATURE_SWEEP_DEFINES_SVH
`define TWO_WAY_EXPONENTIAL_QUADRATURE_SWEEP_DEFINES_SVH

// Same-cycle implication; the consequent may start with a fixed delay.
`define TWEQS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("sweep block check failed");

// Next-cycle implication.
`define TWEQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sweep block check failed");

`endif

>>> sv/tweqs_pkg.sv
// ---------------------------------------------------------------------------
// tweqs_pkg
// Shared constants, codes and types of the two-way exponential quadrature sweep.
// ---------------------------------------------------------------------------
package tweqs_pkg;

  localparam int DEF_MAX_LEN  = 1024;
  localparam int DEF_MAX_TAPS = 15;
  localparam int FRAC_BITS    = 16;
  localparam int MIN_ORDER    = 4;
  localparam int DECAY_ONE    = 65536;

  localparam int MODE_W     = 3;
  localparam int POS_W      = 11;
  localparam int TAP_W      = 4;
  localparam int VAL_W      = 32;
  localparam int LEN_CFG_W  = 11;
  localparam int ORD_W      = 4;
  localparam int DECAY_W    = 17;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DECAY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LWEIGHT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RWEIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OUTPUT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER      = 1'd1;

  // Operations handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_DECAY,
    OP_LWEIGHT,
    OP_RWEIGHT,
    OP_OUTPUT,
    OP_START,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        pos;
    logic [TAP_W-1:0]        tap;
    logic signed [VAL_W-1:0] value;
    logic                    in_range;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_st_t;

endpackage

>>> sv/tweqs_front.sv
// ---------------------------------------------------------------------------
// tweqs_front
// Accepts command items, range-checks them and turns them into queue entries.
// ---------------------------------------------------------------------------
module tweqs_front import tweqs_pkg::*; #(
  parameter int MAX_LEN  = DEF_MAX_LEN,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                    start,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic [TAP_W-1:0]        in_tap,
  input  logic signed [VAL_W-1:0] in_value,
  input  q_st_t                   q_st,
  output logic                    busy,
  output logic                    push,
  output item_t                   item
);

  logic keep;
  logic pos_ok;
  logic out_ok;
  logic tap_ok;
  logic signed [VAL_W-1:0] decay_sat;

  assign pos_ok = 32'(in_position) < 32'(MAX_LEN);
  assign out_ok = 32'(in_position) <= 32'(MAX_LEN);
  assign tap_ok = 32'(in_tap) < 32'(MAX_TAPS);

  // Decay factors are clipped into 0..1.0 on the way in.
  always_comb begin
    if (in_value < 0) begin
      decay_sat = '0;
    end else if (in_value > VAL_W'(DECAY_ONE)) begin
      decay_sat = VAL_W'(DECAY_ONE);
    end else begin
      decay_sat = in_value;
    end
  end

  // Classify the item; loads outside the stores are dropped here.
  always_comb begin
    item.pos      = in_position;
    item.tap      = in_tap;
    item.value    = in_value;
    item.in_range = out_ok;
    item.op       = OP_SAMPLE;
    keep          = 1'b0;
    unique case (in_mode)
      MODE_SAMPLE: begin
        item.op = OP_SAMPLE;
        keep    = pos_ok;
      end
      MODE_DECAY: begin
        item.op    = OP_DECAY;
        item.value = decay_sat;
        keep       = pos_ok;
      end
      MODE_LWEIGHT: begin
        item.op = OP_LWEIGHT;
        keep    = pos_ok && tap_ok;
      end
      MODE_RWEIGHT: begin
        item.op = OP_RWEIGHT;
        keep    = pos_ok && tap_ok;
      end
      MODE_OUTPUT: begin
        item.op = OP_OUTPUT;
        keep    = out_ok;
      end
      MODE_START: begin
        item.op = OP_START;
        keep    = 1'b1;
      end
      MODE_READ: begin
        item.op = OP_READ;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy = q_st.full;
  assign push = start && !busy && keep;

endmodule

>>> sv/tweqs_queue.sv
// ---------------------------------------------------------------------------
// tweqs_queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module tweqs_queue import tweqs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output q_st_t st
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign do_push = push && (count_r != QCNT_W'(QDEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign dout     = mem_r[rd_ptr_r];
  assign st.empty = (count_r == '0);
  assign st.full  = (count_r == QCNT_W'(QDEPTH));
  assign st.count = count_r;

endmodule

>>> sv/tweqs_back.sv
// ---------------------------------------------------------------------------
// tweqs_back
// Executes queued items: store loads, output reads and the two recursive sweeps.
// ---------------------------------------------------------------------------
module tweqs_back import tweqs_pkg::*; #(
  parameter int MAX_LEN  = DEF_MAX_LEN,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  item_t                   item,
  input  q_st_t                   q_st,
  input  logic [LEN_CFG_W-1:0]    seq_length,
  input  logic [ORD_W-1:0]        order,
  output logic                    pop,
  output logic                    idle,
  output logic                    out_strobe,
  output logic [POS_W-1:0]        out_position,
  output logic signed [VAL_W-1:0] out_value
);

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int OIDX_W = $clog2(MAX_LEN + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int WA_W   = $clog2(MAX_LEN * MAX_TAPS);
  localparam int PROD_W = 2 * VAL_W;
  localparam int DOT_W  = 56;
  localparam int DMUL_W = DECAY_W + 1 + ACC_W;
  localparam int SUM_W  = 58;
  localparam int OSUM_W = ACC_W + 1;

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_INIT  = 9'b000000010,
    B_POS   = 9'b000000100,
    B_TAPS  = 9'b000001000,
    B_DRAIN = 9'b000010000,
    B_DECAY = 9'b000100000,
    B_SUM   = 9'b001000000,
    B_OUTWR = 9'b010000000,
    B_DONE  = 9'b100000000
  } bstate_t;

  // Stores.
  logic signed [VAL_W-1:0] sample_mem [MAX_LEN];
  logic [DECAY_W-1:0]      decay_mem  [MAX_LEN];
  logic signed [VAL_W-1:0] lw_mem     [MAX_LEN * MAX_TAPS];
  logic signed [VAL_W-1:0] rw_mem     [MAX_LEN * MAX_TAPS];
  logic signed [VAL_W-1:0] out_mem    [MAX_LEN + 1];

  logic signed [VAL_W-1:0] s_q;
  logic [DECAY_W-1:0]      d_q;
  logic signed [VAL_W-1:0] lw_q;
  logic signed [VAL_W-1:0] rw_q;
  logic signed [VAL_W-1:0] o_q;

  // Store port controls.
  logic                    s_we, s_re, d_we, d_re, lw_we, rw_we, w_re, o_we, o_re;
  logic [IDX_W-1:0]        s_wa, s_ra, d_wa, d_ra;
  logic [WA_W-1:0]         w_wa, w_ra;
  logic [OIDX_W-1:0]       o_wa, o_ra;
  logic signed [VAL_W-1:0] o_wd;

  // Sequencer state.
  bstate_t                  state_r, state_nxt;
  logic                     dir_r, dir_nxt;
  logic [LEN_W-1:0]         i_r, i_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [TAP_W-1:0]         taps_r, taps_nxt;
  logic [TAP_W-1:0]         half_r, half_nxt;
  logic [TAP_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         wstart_r, wstart_nxt;
  logic [WA_W-1:0]          wbase_r, wbase_nxt;
  logic [OIDX_W-1:0]        oaddr_r, oaddr_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DOT_W-1:0]  dot_r;
  logic                     dot_clr;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DMUL_W-1:0] dmul_r;
  logic                     issue, iss_v_r, prod_v_r;
  logic                     rsp_v_r, rsp_oor_r;
  logic [POS_W-1:0]         rsp_pos_r;
  logic                     rd_issue;

  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic signed [OSUM_W-1:0] osum;
  logic signed [VAL_W-1:0]  osum_sat;
  logic signed [VAL_W-1:0]  w_sel;

  int ord_i, taps_i, len_i, st_i, lim_i;

  assign pop  = (state_r == B_IDLE) && !q_st.empty;
  assign idle = (state_r == B_IDLE);

  // Sample store.
  always_ff @(posedge clk) begin
    if (s_we) begin
      sample_mem[s_wa] <= item.value;
    end
    if (s_re) begin
      s_q <= sample_mem[s_ra];
    end
  end

  // Decay store.
  always_ff @(posedge clk) begin
    if (d_we) begin
      decay_mem[d_wa] <= item.value[DECAY_W-1:0];
    end
    if (d_re) begin
      d_q <= decay_mem[d_ra];
    end
  end

  // Left weight store.
  always_ff @(posedge clk) begin
    if (lw_we) begin
      lw_mem[w_wa] <= item.value;
    end
    if (w_re) begin
      lw_q <= lw_mem[w_ra];
    end
  end

  // Right weight store.
  always_ff @(posedge clk) begin
    if (rw_we) begin
      rw_mem[w_wa] <= item.value;
    end
    if (w_re) begin
      rw_q <= rw_mem[w_ra];
    end
  end

  // Output store.
  always_ff @(posedge clk) begin
    if (o_we) begin
      out_mem[o_wa] <= o_wd;
    end
    if (o_re) begin
      o_q <= out_mem[o_ra];
    end
  end

  // Sweep arithmetic: decayed state plus window dot product, then output update.
  always_comb begin
    sum = SUM_W'(dmul_r >>> FRAC_BITS) + SUM_W'(dot_r);
    if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1) begin
      sum_sat = sum[ACC_W-1:0];
    end else begin
      sum_sat = sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    osum = OSUM_W'(o_q) + OSUM_W'(acc_r);
    if (osum[OSUM_W-1:VAL_W-1] == '0 || osum[OSUM_W-1:VAL_W-1] == '1) begin
      osum_sat = osum[VAL_W-1:0];
    end else begin
      osum_sat = osum[OSUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    w_sel = dir_r ? rw_q : lw_q;
  end

  // Sequencer and store port control.
  always_comb begin
    state_nxt  = state_r;
    dir_nxt    = dir_r;
    i_nxt      = i_r;
    len_nxt    = len_r;
    taps_nxt   = taps_r;
    half_nxt   = half_r;
    k_nxt      = k_r;
    wstart_nxt = wstart_r;
    wbase_nxt  = wbase_r;
    oaddr_nxt  = oaddr_r;
    acc_nxt    = acc_r;
    dot_clr    = 1'b0;
    issue      = 1'b0;
    rd_issue   = 1'b0;
    s_we = 1'b0; d_we = 1'b0; lw_we = 1'b0; rw_we = 1'b0; o_we = 1'b0;
    s_re = 1'b0; d_re = 1'b0; w_re = 1'b0; o_re = 1'b0;
    s_wa = IDX_W'(item.pos);
    d_wa = IDX_W'(item.pos);
    w_wa = WA_W'(32'(item.pos) * MAX_TAPS + 32'(item.tap));
    s_ra = IDX_W'(32'(wstart_r) + 32'(k_r));
    w_ra = WA_W'(32'(wbase_r) + 32'(k_r));
    d_ra = IDX_W'(i_r);
    o_wa = OIDX_W'(item.pos);
    o_ra = OIDX_W'(item.pos);
    o_wd = item.value;
    ord_i  = 0;
    taps_i = 0;
    len_i  = 0;
    st_i   = 0;
    lim_i  = 0;
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          unique case (item.op)
            OP_SAMPLE:  s_we  = 1'b1;
            OP_DECAY:   d_we  = 1'b1;
            OP_LWEIGHT: lw_we = 1'b1;
            OP_RWEIGHT: rw_we = 1'b1;
            OP_OUTPUT:  o_we  = 1'b1;
            OP_START:   state_nxt = B_INIT;
            OP_READ: begin
              o_re     = item.in_range;
              rd_issue = 1'b1;
            end
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_INIT: begin
        // Clamp order and length once per start.
        ord_i = int'(order);
        if (ord_i < MIN_ORDER) ord_i = MIN_ORDER;
        if (ord_i > MAX_TAPS - 1) ord_i = MAX_TAPS - 1;
        taps_i = ord_i + 1;
        len_i  = int'(seq_length);
        if (len_i > MAX_LEN) len_i = MAX_LEN;
        if (len_i < taps_i) len_i = taps_i;
        taps_nxt  = TAP_W'(taps_i);
        half_nxt  = TAP_W'(ord_i / 2);
        len_nxt   = LEN_W'(len_i);
        i_nxt     = '0;
        wbase_nxt = '0;
        dir_nxt   = 1'b0;
        acc_nxt   = '0;
        state_nxt = B_POS;
      end
      B_POS: begin
        // Window start, clamped into the line; fetch the decay factor.
        st_i  = int'(i_r) - int'(half_r);
        lim_i = int'(len_r) - int'(taps_r);
        if (st_i > lim_i) st_i = lim_i;
        if (st_i < 0) st_i = 0;
        wstart_nxt = IDX_W'(st_i);
        k_nxt      = '0;
        dot_clr    = 1'b1;
        d_re       = 1'b1;
        state_nxt  = B_TAPS;
      end
      B_TAPS: begin
        issue = 1'b1;
        s_re  = 1'b1;
        w_re  = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == taps_r - 1'b1) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!iss_v_r && !prod_v_r) begin
          state_nxt = B_DECAY;
        end
      end
      B_DECAY: begin
        state_nxt = B_SUM;
      end
      B_SUM: begin
        acc_nxt   = sum_sat;
        oaddr_nxt = dir_r ? OIDX_W'(i_r) : OIDX_W'(32'(i_r) + 1);
        o_ra      = dir_r ? OIDX_W'(i_r) : OIDX_W'(32'(i_r) + 1);
        o_re      = 1'b1;
        state_nxt = B_OUTWR;
      end
      B_OUTWR: begin
        o_we = 1'b1;
        o_wa = oaddr_r;
        o_wd = osum_sat;
        state_nxt = B_POS;
        if (!dir_r) begin
          if (32'(i_r) == 32'(len_r) - 1) begin
            // Left sweep done: the right sweep starts at the same position.
            dir_nxt = 1'b1;
            acc_nxt = '0;
          end else begin
            i_nxt     = LEN_W'(32'(i_r) + 1);
            wbase_nxt = WA_W'(32'(wbase_r) + MAX_TAPS);
          end
        end else begin
          if (i_r == '0) begin
            state_nxt = B_DONE;
          end else begin
            i_nxt     = LEN_W'(32'(i_r) - 1);
            wbase_nxt = WA_W'(32'(wbase_r) - MAX_TAPS);
          end
        end
      end
      B_DONE: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      iss_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
      rsp_v_r  <= 1'b0;
      acc_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      iss_v_r  <= issue;
      prod_v_r <= iss_v_r;
      rsp_v_r  <= rd_issue;
      acc_r    <= acc_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dir_r    <= dir_nxt;
    i_r      <= i_nxt;
    len_r    <= len_nxt;
    taps_r   <= taps_nxt;
    half_r   <= half_nxt;
    k_r      <= k_nxt;
    wstart_r <= wstart_nxt;
    wbase_r  <= wbase_nxt;
    oaddr_r  <= oaddr_nxt;
    if (iss_v_r) begin
      prod_r <= w_sel * s_q;
    end
    if (dot_clr) begin
      dot_r <= '0;
    end else if (prod_v_r) begin
      dot_r <= dot_r + DOT_W'(prod_r >>> FRAC_BITS);
    end
    if (state_r == B_DECAY) begin
      dmul_r <= $signed({1'b0, d_q}) * acc_r;
    end
    if (rd_issue) begin
      rsp_pos_r <= item.pos;
      rsp_oor_r <= !item.in_range;
    end
  end

  assign out_strobe   = rsp_v_r;
  assign out_position = rsp_pos_r;
  assign out_value    = rsp_oor_r ? '0 : o_q;

endmodule

>>> sv/two_way_exponential_quadrature_sweep.sv
// ---------------------------------------------------------------------------
// two_way_exponential_quadrature_sweep
// Loads a line of samples, decays and window weights, runs a left and a
// right recursive exponential sweep into the output words, and reads them back.
//
//   channel  direction  handshake           payload
//   in_      input      start / busy        in_mode, in_position, in_tap, in_value
//   out_     output     out_strobe          out_position, out_value
//   cfg_     input      cfg_we              cfg_index, cfg_data
//
// Load items are written into their stores as they leave the queue, and the back
// end stays idle to take the next item; a read returns its registered word on out_strobe.
// During a start, every position fetches one sample/weight pair per cycle
// through the single store read ports.
// busy is high while the two-entry queue is full. Reset is synchronous and
// clears control state only. Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
module two_way_exponential_quadrature_sweep import tweqs_pkg::*; #(
  parameter int MAX_LEN  = DEF_MAX_LEN,
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic [TAP_W-1:0]        in_tap,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_strobe,
  output logic [POS_W-1:0]        out_position,
  output logic signed [VAL_W-1:0] out_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

`include "two_way_exponential_quadrature_sweep_defines.svh"

  logic [LEN_CFG_W-1:0] seq_length_r;
  logic [ORD_W-1:0]     order_r;
  logic                 push;
  logic                 pop;
  logic                 back_idle;
  item_t                f_item;
  item_t                q_item;
  q_st_t                q_st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_length_r <= LEN_CFG_W'(16);
      order_r      <= ORD_W'(MIN_ORDER);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEQ_LENGTH: seq_length_r <= cfg_data[LEN_CFG_W-1:0];
        CFG_ORDER:      order_r      <= cfg_data[ORD_W-1:0];
        default:        order_r      <= order_r;
      endcase
    end
  end

  tweqs_front #(
    .MAX_LEN  (MAX_LEN),
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .start       (start),
    .in_mode     (in_mode),
    .in_position (in_position),
    .in_tap      (in_tap),
    .in_value    (in_value),
    .q_st        (q_st),
    .busy        (busy),
    .push        (push),
    .item        (f_item)
  );

  tweqs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .pop   (pop),
    .dout  (q_item),
    .st    (q_st)
  );

  tweqs_back #(
    .MAX_LEN  (MAX_LEN),
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (q_item),
    .q_st         (q_st),
    .seq_length   (seq_length_r),
    .order        (order_r),
    .pop          (pop),
    .idle         (back_idle),
    .out_strobe   (out_strobe),
    .out_position (out_position),
    .out_value    (out_value)
  );

  // The queue only fills through a transfer on the input side.
  `TWEQS_ASSERT_NEXT(a_fill_needs_push, !busy && !start, !busy)
  // A read into an empty, idle block answers once it has passed the queue and the output store read.
  `TWEQS_ASSERT_NOW(a_read_latency, start && !busy && in_mode == MODE_READ && q_st.empty && back_idle, ##2 out_strobe)
  // When the queue is full, the fill count equals the queue depth.
  `TWEQS_ASSERT_NOW(a_count_bound, q_st.full, q_st.count == QCNT_W'(QDEPTH))

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// Testbench for the two-way exponential quadrature sweep
// Loads samples, decays, weights and output words, runs sweeps and reads the
// output words back. Every read is checked against a bit-exact predictor that
// tracks the stores, the registers and the saturating fixed-point sweeps.
// ---------------------------------------------------------------------------
class sweep_scoreboard;
  typedef struct {
    logic [10:0]        pos;
    logic signed [31:0] val;
  } word_t;

  logic [10:0]        len_reg;
  logic [3:0]         ord_reg;
  logic signed [31:0] sample_mem[1024];
  logic [16:0]        decay_mem[1024];
  logic signed [31:0] lweight_mem[15360];
  logic signed [31:0] rweight_mem[15360];
  logic signed [31:0] out_mem[1025];
  logic signed [47:0] acc;
  word_t              pending_reads[$];
  int                 errors;

  function new();
    len_reg = 11'd16;
    ord_reg = 4'd4;
    acc     = '0;
    errors  = 0;
    foreach (sample_mem[i]) begin
      sample_mem[i] = '0;
      decay_mem[i]  = '0;
    end
    foreach (lweight_mem[i]) begin
      lweight_mem[i] = '0;
      rweight_mem[i] = '0;
    end
    foreach (out_mem[i]) out_mem[i] = '0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [10:0] data);
    if (idx == tweqs_pkg::CFG_SEQ_LENGTH) len_reg = data;
    else ord_reg = data[3:0];
  endfunction

  // Effective taps and length after clamping.
  function int taps();
    int o;
    o = ord_reg;
    if (o < 4) o = 4;
    if (o > 14) o = 14;
    return o + 1;
  endfunction

  function int line_len();
    int l;
    l = len_reg;
    if (l > 1024) l = 1024;
    if (l < taps()) l = taps();
    return l;
  endfunction

  function int pending();
    return pending_reads.size();
  endfunction

  // One recursive step at position i with the given weight bank.
  function void step(int i, bit right_bank, int len, int nt, int half);
    int                 first;
    logic signed [79:0] a80, d80, w80, s80, sum;
    first = i - half;
    if (first > len - nt) first = len - nt;
    if (first < 0) first = 0;
    a80 = acc;
    d80 = {63'd0, decay_mem[i]};
    sum = (d80 * a80) >>> 16;
    for (int k = 0; k < nt; k++) begin
      w80 = right_bank ? rweight_mem[i * 15 + k] : lweight_mem[i * 15 + k];
      s80 = sample_mem[first + k];
      sum = sum + ((w80 * s80) >>> 16);
    end
    if (sum > 80'sh0000_0000_7FFF_FFFF_FFFF) acc = 48'sh7FFF_FFFF_FFFF;
    else if (sum < -80'sh0000_0000_8000_0000_0000) acc = 48'sh8000_0000_0000;
    else acc = sum[47:0];
  endfunction

  function logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [47:0] b);
    logic signed [48:0] s;
    s = a + b;
    if (s > 49'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -49'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function void run_sweeps();
    int len, nt, half;
    nt   = taps();
    half = (nt - 1) / 2;
    len  = line_len();
    acc  = '0;
    for (int i = 0; i < len; i++) begin
      step(i, 1'b0, len, nt, half);
      out_mem[i + 1] = add_sat(out_mem[i + 1], acc);
    end
    acc = '0;
    for (int i = len - 1; i >= 0; i--) begin
      step(i, 1'b1, len, nt, half);
      out_mem[i] = add_sat(out_mem[i], acc);
    end
  endfunction

  // Notes one accepted input transfer.
  function void note_item(logic [2:0] mode, logic [10:0] pos, logic [3:0] tap,
                          logic signed [31:0] val);
    word_t w;
    case (mode)
      tweqs_pkg::MODE_SAMPLE: if (pos < 1024) sample_mem[pos] = val;
      tweqs_pkg::MODE_DECAY: begin
        if (pos < 1024) decay_mem[pos] = (val < 0) ? 17'd0 :
                                         (val > 65536) ? 17'd65536 : val[16:0];
      end
      tweqs_pkg::MODE_LWEIGHT: if (pos < 1024 && tap < 15) lweight_mem[pos * 15 + tap] = val;
      tweqs_pkg::MODE_RWEIGHT: if (pos < 1024 && tap < 15) rweight_mem[pos * 15 + tap] = val;
      tweqs_pkg::MODE_OUTPUT: if (pos <= 1024) out_mem[pos] = val;
      tweqs_pkg::MODE_START: run_sweeps();
      tweqs_pkg::MODE_READ: begin
        w.pos = pos;
        w.val = (pos <= 1024) ? out_mem[pos] : 32'sd0;
        pending_reads.push_back(w);
      end
      default: ;
    endcase
  endfunction

  // Checks one result transfer against the oldest expected read.
  function void check_result(logic [10:0] pos, logic signed [31:0] val);
    word_t w;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected result pos %0d value %0d", $time, pos, val);
      errors++;
      return;
    end
    w = pending_reads.pop_front();
    if (pos !== w.pos) begin
      $display("%0t: out_position expected %0d actual %0d", $time, w.pos, pos);
      errors++;
    end
    if (val !== w.val) begin
      $display("%0t: out_value at %0d expected %0d actual %0d", $time, w.pos, w.val, val);
      errors++;
    end
  endfunction
endclass

module tb import tweqs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [MODE_W-1:0]        in_mode;
  logic [POS_W-1:0]         in_position;
  logic [TAP_W-1:0]         in_tap;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_strobe;
  logic [POS_W-1:0]         out_position;
  logic signed [VAL_W-1:0]  out_value;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  sweep_scoreboard sb;
  int              sent;
  bit              no_gaps;

  // Which store entries hold a defined value in the block.
  bit sample_set[1024];
  bit decay_set[1024];
  bit lweight_set[1024][15];
  bit rweight_set[1024][15];
  bit out_set[1025];

  two_way_exponential_quadrature_sweep u_top (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_position, out_value);
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [31:0] data_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2 ** 19) - 2 ** 18;
    if (r < 80) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] decay_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(40000, 65536);
    if (r < 90) return $urandom_range(0, 1) ? 0 : 65536;
    return $urandom;
  endfunction

  // Sends one input transfer after a random gap and notes it on acceptance.
  task automatic send_item(logic [2:0] mode, logic [10:0] pos, logic [3:0] tap,
                           logic signed [31:0] val);
    int g, r;
    r = $urandom_range(0, 99);
    g = (no_gaps || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    start       = 1'b1;
    in_mode     = mode;
    in_position = pos;
    in_tap      = tap;
    in_value    = val;
    do @(posedge clk); while (busy);
    sb.note_item(mode, pos, tap, val);
    sent++;
    if (mode == MODE_SAMPLE && pos < 1024) sample_set[pos] = 1'b1;
    if (mode == MODE_DECAY && pos < 1024) decay_set[pos] = 1'b1;
    if (mode == MODE_LWEIGHT && pos < 1024 && tap < 15) lweight_set[pos][tap] = 1'b1;
    if (mode == MODE_RWEIGHT && pos < 1024 && tap < 15) rweight_set[pos][tap] = 1'b1;
    if (mode == MODE_OUTPUT && pos <= 1024) out_set[pos] = 1'b1;
  endtask

  // Waits for every expected read; the read queue is in order, so any
  // earlier sweep is done by then.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [10:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Defines every entry that a sweep with the current setting will touch.
  task automatic fill_for_sweep();
    int len, nt;
    len = sb.line_len();
    nt  = sb.taps();
    for (int i = 0; i < len; i++) begin
      if (!sample_set[i]) send_item(MODE_SAMPLE, i, 0, data_word());
      if (!decay_set[i]) send_item(MODE_DECAY, i, 0, decay_word());
      for (int k = 0; k < nt; k++) begin
        if (!lweight_set[i][k]) send_item(MODE_LWEIGHT, i, k, data_word());
        if (!rweight_set[i][k]) send_item(MODE_RWEIGHT, i, k, data_word());
      end
    end
    for (int i = 0; i <= len; i++)
      if (!out_set[i]) send_item(MODE_OUTPUT, i, 0, data_word());
  endtask

  // Reads a word, defining it first if the block holds nothing there.
  task automatic read_word(logic [10:0] pos);
    if (pos <= 1024 && !out_set[pos]) send_item(MODE_OUTPUT, pos, 0, data_word());
    send_item(MODE_READ, pos, 0, 0);
  endtask

  // Random items over one setting of the registers.
  task automatic random_phase(int n);
    int          len, r;
    logic [10:0] p;
    fill_for_sweep();
    len = sb.line_len();
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, len - 1);
      if (r < 12) send_item(MODE_SAMPLE, p, 0, data_word());
      else if (r < 20) send_item(MODE_DECAY, p, 0, decay_word());
      else if (r < 28) send_item(MODE_LWEIGHT, p, $urandom_range(0, sb.taps() - 1), data_word());
      else if (r < 36) send_item(MODE_RWEIGHT, p, $urandom_range(0, sb.taps() - 1), data_word());
      else if (r < 41) send_item(MODE_OUTPUT, $urandom_range(0, len), 0, data_word());
      else if (r < 48) send_item(MODE_START, $urandom, $urandom, $urandom);
      else if (r < 85) read_word($urandom_range(0, len));
      else if (r < 88) read_word($urandom_range(0, 1024));
      else if (r < 91) send_item(MODE_READ, $urandom_range(1025, 2047), $urandom, $urandom);
      else if (r < 97)
        // Loads outside the stores are dropped by the block.
        send_item($urandom_range(0, 4), $urandom_range(1025, 2047), $urandom, $urandom);
      else if (r < 99) send_item($urandom_range(2, 3), p, 15, $urandom);
      else send_item(MODE_UNUSED, $urandom, $urandom, $urandom);
    end
    read_word($urandom_range(0, len));
    drain();
  endtask

  initial begin
    sb          = new();
    sent        = 0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = '0;
    in_position = '0;
    in_tap      = '0;
    in_value    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset setting, field extremes and the ignored cases.
    write_reg(CFG_SEQ_LENGTH, 11'd16);
    write_reg(CFG_ORDER, 4'd4);
    send_item(MODE_DECAY, 0, 0, -32'sd1);
    send_item(MODE_DECAY, 1, 0, 32'sd70000);
    send_item(MODE_DECAY, 2, 0, 32'sd65536);
    send_item(MODE_SAMPLE, 0, 0, 32'sh7FFF_FFFF);
    send_item(MODE_SAMPLE, 1, 0, 32'sh8000_0000);
    send_item(MODE_LWEIGHT, 0, 0, 32'sh7FFF_FFFF);
    send_item(MODE_RWEIGHT, 15, 4, 32'sh8000_0000);
    send_item(MODE_SAMPLE, 1024, 0, 32'sd5);
    send_item(MODE_LWEIGHT, 3, 15, 32'sd5);
    send_item(MODE_OUTPUT, 1024, 0, 32'sh7FFF_FFFF);
    send_item(MODE_OUTPUT, 1025, 0, 32'sd9);
    send_item(MODE_UNUSED, 11'h7FF, 4'hF, 32'shFFFF_FFFF);
    send_item(MODE_READ, 1024, 0, 0);
    send_item(MODE_READ, 11'h7FF, 4'hF, 32'shFFFF_FFFF);
    fill_for_sweep();
    send_item(MODE_START, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_READ, 16, 0, 0);
    drain();

    // Register extremes, including clamped values.
    write_reg(CFG_SEQ_LENGTH, 11'd5);
    random_phase(60);
    write_reg(CFG_SEQ_LENGTH, 11'd0);
    write_reg(CFG_ORDER, 4'd15);
    random_phase(60);
    write_reg(CFG_ORDER, 4'd0);
    no_gaps = 1'b1;
    random_phase(80);
    no_gaps = 1'b0;

    // Longer line at the widest window.
    write_reg(CFG_SEQ_LENGTH, 11'd24);
    write_reg(CFG_ORDER, 4'd14);
    random_phase(30);

    while (sent < 1350) begin
      write_reg(CFG_SEQ_LENGTH, $urandom_range(0, 9) == 0 ? $urandom_range(0, 4)
                                                        : $urandom_range(5, 24));
      write_reg(CFG_ORDER, $urandom_range(0, 15));
      no_gaps = ($urandom_range(0, 3) == 0);
      random_phase($urandom_range(40, 100));
    end
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/tweqs_pkg.sv
sv/tweqs_front.sv
sv/tweqs_queue.sv
sv/tweqs_back.sv
sv/two_way_exponential_quadrature_sweep.sv
tb/tb.sv
